>>> src/pscf_pkg.sv
// Shared types, codes and constants of the point set force block.
`timescale 1ns / 1ps
package pscf_pkg;

  typedef logic [63:0] dword_t;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [1:0] CFG_POINT_COUNT     = 2'd0;
  localparam logic [1:0] CFG_OVERLAP_RADIUS  = 2'd1;
  localparam logic [1:0] CFG_GAIN            = 2'd2;
  localparam logic [1:0] CFG_CHARGE_NEGATIVE = 2'd3;

  localparam logic [30:0] RADIUS_RST = 31'd1966080;
  localparam logic [30:0] GAIN_RST   = 31'd786432;

  localparam dword_t TERM_CAP = 64'h0000_0100_0000_0000;

  // Handshake of an iterative arithmetic unit.
  typedef struct packed {
    logic go;
  } unit_req_t;

  typedef struct packed {
    logic done;
  } unit_rsp_t;

endpackage

>>> src/pscf_mul.sv
// Registered 32 by 32 bit unsigned multiplier shared by the sequencer.
`timescale 1ns / 1ps
module pscf_mul
  import pscf_pkg::*;
(
  input  logic        clk,
  input  logic [31:0] mul_a,
  input  logic [31:0] mul_b,
  output dword_t      prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= dword_t'(mul_a) * dword_t'(mul_b);
  end

endmodule

>>> src/pscf_div.sv
// Restoring divider, 64 by 64 bits, one quotient bit per cycle.
`timescale 1ns / 1ps
module pscf_div
  import pscf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  unit_req_t req,
  input  dword_t    num,
  input  dword_t    den,
  output unit_rsp_t rsp,
  output dword_t    quo_r
);

  logic        run_r;
  logic        done_r;
  logic [5:0]  cnt_r;
  dword_t      rem_r;
  dword_t      den_r;
  logic [64:0] trial;
  logic        fits;

  always_comb begin
    trial = {rem_r, quo_r[63]};
    fits  = trial >= {1'b0, den_r};
  end

  assign rsp.done = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.go) begin
        run_r <= 1'b1;
        cnt_r <= '0;
        rem_r <= '0;
        quo_r <= num;
        den_r <= den;
      end else if (run_r) begin
        rem_r <= fits ? 64'(trial - {1'b0, den_r}) : trial[63:0];
        quo_r <= {quo_r[62:0], fits};
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

>>> src/pscf_sqrt.sv
// Integer square root of a 64 bit value, one result bit per cycle.
`timescale 1ns / 1ps
module pscf_sqrt
  import pscf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  unit_req_t   req,
  input  dword_t      rad,
  output unit_rsp_t   rsp,
  output logic [31:0] root
);

  logic   run_r;
  logic   done_r;
  logic [4:0] cnt_r;
  dword_t n_r;
  dword_t r_r;
  dword_t b_r;
  dword_t rb;

  assign rb       = r_r + b_r;
  assign rsp.done = done_r;
  assign root     = r_r[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.go) begin
        run_r <= 1'b1;
        cnt_r <= '0;
        n_r   <= rad;
        r_r   <= '0;
        b_r   <= 64'h4000_0000_0000_0000;
      end else if (run_r) begin
        if (n_r >= rb) begin
          n_r <= n_r - rb;
          r_r <= (r_r >> 1) + b_r;
        end else begin
          r_r <= r_r >> 1;
        end
        b_r   <= b_r >> 2;
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

>>> src/point_set_coulomb_force.sv
// Top level: point table memory and the sequencer that sums the force field.
`timescale 1ns / 1ps
// A write command (command 0) stores one Q16.16 point into the table in the cycle of its
// transfer and gives no result; busy stays low. A query command (command 1) raises busy
// and walks the first point_count entries of the table (at most MAX_POINTS), each read
// from a synchronous memory with one write and one read port, through a shared
// bit-serial divider, a bit-serial square root and one registered 32 by 32 multiplier.
// Most of the work on each walked point lies in up to six 64-step divisions and one
// 32-step root. A query stops early at the first point inside the overlap radius. The
// Q8.24 force appears on the out_ ports for exactly one cycle with out_valid high and
// busy already low again; the receiver cannot hold it off, so it must capture the
// transfer in that cycle. Configuration writes are taken only while busy is low.
module point_set_coulomb_force
  import pscf_pkg::*;
#(
  parameter int MAX_POINTS = 256,
  parameter int FRAC_BITS  = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_command,
  input  logic [7:0]         in_point_index,
  input  logic signed [31:0] in_coord_x,
  input  logic signed [31:0] in_coord_y,
  input  logic signed [31:0] in_coord_z,
  output logic               out_valid,
  output logic signed [31:0] out_force_x,
  output logic signed [31:0] out_force_y,
  output logic signed [31:0] out_force_z,
  output logic               out_overlapped,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int OV_SH = FRAC_BITS + 6;
  localparam int SUM_SH = 38 - FRAC_BITS;

  typedef enum logic [4:0] {
    S_IDLE, S_RR_ISSUE, S_RR_TAKE, S_RD, S_DIFF, S_SQ_ISSUE, S_SQ_TAKE,
    S_SQRT_GO, S_SQRT_WAIT, S_U_GO, S_U_WAIT, S_OV_ISSUE, S_OV_TAKE,
    S_T_GO, S_T_WAIT, S_TLO_ISSUE, S_TLO_TAKE, S_THI_ISSUE, S_THI_TAKE
  } state_t;

  state_t state_r;

  // Configuration registers.
  logic [8:0]  count_r;
  logic [30:0] radius_r;
  logic [30:0] gain_r;
  logic        chg_r;

  // The table holds x, y and z of a point in one word.
  logic [95:0] mem [MAX_POINTS];
  logic [95:0] rd_r;
  logic        mem_we;
  logic [IDX_W-1:0] mem_wa;

  logic signed [31:0] probe_r [3];
  logic [CNT_W-1:0]   idx_r;
  logic [CNT_W-1:0]   n_lim;
  logic [1:0]         k_r;
  logic [61:0]        rr_r;
  dword_t             sum_r;
  logic [31:0]        q_r;
  logic [1:0]         s_r;
  logic [30:0]        e_r [3];
  logic               neg_r [3];
  logic [30:0]        u_r [3];
  dword_t             t_r;
  dword_t             plo_r;
  logic               ov_r;
  logic signed [63:0] acc_r [3];
  logic signed [31:0] out_r [3];
  logic               out_valid_r;
  logic               out_ov_r;

  // Arithmetic units.
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  dword_t      prod_r;
  unit_req_t   div_req;
  unit_rsp_t   div_rsp;
  dword_t      div_num;
  dword_t      div_den;
  dword_t      div_q;
  unit_req_t   sq_req;
  unit_rsp_t   sq_rsp;
  logic [31:0] sq_root;

  // Difference of probe and point.
  logic [32:0] d_w [3];
  logic [32:0] a_w [3];
  logic [1:0]  s_w;

  // Sum term.
  logic [95:0] full_w;
  dword_t      mag_w;
  dword_t      ovmag_w;
  logic [6:0]  sh_w;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] res;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      res = 32'sh7FFF_FFFF;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      res = 32'sh8000_0000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

  assign busy           = (state_r != S_IDLE);
  assign cfg_ready      = !busy;
  assign out_valid      = out_valid_r;
  assign out_force_x    = out_r[0];
  assign out_force_y    = out_r[1];
  assign out_force_z    = out_r[2];
  assign out_overlapped = out_ov_r;

  assign n_lim = ({23'd0, count_r} > MAX_POINTS) ? CNT_W'(MAX_POINTS) : CNT_W'(count_r);

  assign mem_we = start && !busy && (in_command == CMD_WRITE) &&
                  (32'(in_point_index) < MAX_POINTS);
  assign mem_wa = IDX_W'(in_point_index);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= {in_coord_x, in_coord_y, in_coord_z};
    end
    rd_r <= mem[idx_r[IDX_W-1:0]];
  end

  always_comb begin
    logic [31:0] pt [3];
    pt[0] = rd_r[95:64];
    pt[1] = rd_r[63:32];
    pt[2] = rd_r[31:0];
    for (int k = 0; k < 3; k++) begin
      d_w[k] = {probe_r[k][31], probe_r[k]} - {pt[k][31], pt[k]};
      a_w[k] = d_w[k][32] ? 33'(~d_w[k] + 33'd1) : d_w[k];
    end
    if (a_w[0][32] || a_w[1][32] || a_w[2][32]) begin
      s_w = 2'd2;
    end else if (a_w[0][31] || a_w[1][31] || a_w[2][31]) begin
      s_w = 2'd1;
    end else begin
      s_w = 2'd0;
    end
  end

  // Magnitude of one summed term, capped.
  always_comb begin
    full_w = {prod_r, 32'd0} + {32'd0, plo_r};
    sh_w   = 7'(SUM_SH) + {4'd0, s_r, 1'b0};
    if (|full_w[95:64]) begin
      mag_w = TERM_CAP;
    end else begin
      mag_w = full_w[63:0] >> sh_w;
      if (mag_w > TERM_CAP) begin
        mag_w = TERM_CAP;
      end
    end
    ovmag_w = prod_r >> OV_SH;
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_RR_ISSUE: begin
        mul_a = {1'b0, radius_r};
        mul_b = {1'b0, radius_r};
      end
      S_SQ_ISSUE: begin
        mul_a = {1'b0, e_r[k_r]};
        mul_b = {1'b0, e_r[k_r]};
      end
      S_OV_ISSUE: begin
        mul_a = {1'b0, gain_r};
        mul_b = {1'b0, u_r[k_r]};
      end
      S_TLO_ISSUE: begin
        mul_a = {1'b0, gain_r};
        mul_b = t_r[31:0];
      end
      S_THI_ISSUE: begin
        mul_a = {1'b0, gain_r};
        mul_b = t_r[63:32];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    div_req.go = 1'b0;
    div_num    = '0;
    div_den    = '0;
    if (state_r == S_U_GO) begin
      div_req.go = (q_r != 32'd0);
      div_num    = {3'd0, e_r[k_r], 30'd0};
      div_den    = {32'd0, q_r};
    end else if (state_r == S_T_GO) begin
      div_req.go = 1'b1;
      div_num    = {1'b0, u_r[k_r], 32'd0};
      div_den    = sum_r;
    end
    sq_req.go = (state_r == S_SQRT_GO);
  end

  pscf_mul u_mul (
    .clk    (clk),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .prod_r (prod_r)
  );

  pscf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .num   (div_num),
    .den   (div_den),
    .rsp   (div_rsp),
    .quo_r (div_q)
  );

  pscf_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (sq_req),
    .rad   (sum_r),
    .rsp   (sq_rsp),
    .root  (sq_root)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      radius_r    <= RADIUS_RST;
      gain_r      <= GAIN_RST;
      chg_r       <= 1'b0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      k_r         <= '0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_POINT_COUNT:     count_r  <= cfg_data[8:0];
          CFG_OVERLAP_RADIUS:  radius_r <= cfg_data[30:0];
          CFG_GAIN:            gain_r   <= cfg_data[30:0];
          CFG_CHARGE_NEGATIVE: chg_r    <= cfg_data[0];
          default:             chg_r    <= chg_r;
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          if (start && (in_command == CMD_QUERY)) begin
            probe_r[0] <= in_coord_x;
            probe_r[1] <= in_coord_y;
            probe_r[2] <= in_coord_z;
            idx_r      <= '0;
            state_r    <= S_RR_ISSUE;
          end
        end
        S_RR_ISSUE: state_r <= S_RR_TAKE;
        S_RR_TAKE: begin
          rr_r <= prod_r[61:0];
          for (int k = 0; k < 3; k++) begin
            acc_r[k] <= '0;
          end
          idx_r   <= '0;
          state_r <= S_RD;
        end
        S_RD: begin
          // The read address is idx_r; the word is ready in the next cycle.
          if (idx_r == n_lim) begin
            for (int k = 0; k < 3; k++) begin
              out_r[k] <= sat32(chg_r ? -acc_r[k] : acc_r[k]);
            end
            out_ov_r    <= 1'b0;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end else begin
            state_r <= S_DIFF;
          end
        end
        S_DIFF: begin
          for (int k = 0; k < 3; k++) begin
            e_r[k]   <= 31'(a_w[k] >> s_w);
            neg_r[k] <= d_w[k][32];
          end
          s_r     <= s_w;
          sum_r   <= '0;
          k_r     <= 2'd0;
          state_r <= S_SQ_ISSUE;
        end
        S_SQ_ISSUE: state_r <= S_SQ_TAKE;
        S_SQ_TAKE: begin
          sum_r <= sum_r + prod_r;
          if (k_r == 2'd2) begin
            state_r <= S_SQRT_GO;
          end else begin
            k_r     <= k_r + 2'd1;
            state_r <= S_SQ_ISSUE;
          end
        end
        S_SQRT_GO: state_r <= S_SQRT_WAIT;
        S_SQRT_WAIT: begin
          if (sq_rsp.done) begin
            q_r     <= sq_root;
            ov_r    <= (s_r == 2'd0) && (sum_r < {2'd0, rr_r});
            k_r     <= 2'd0;
            state_r <= S_U_GO;
          end
        end
        S_U_GO: begin
          // A zero root means a zero difference, which has no direction.
          if (q_r == 32'd0) begin
            u_r[k_r] <= '0;
            if (k_r == 2'd2) begin
              k_r <= 2'd0;
              if (ov_r) begin
                state_r <= S_OV_ISSUE;
              end else begin
                idx_r   <= idx_r + CNT_W'(1);
                state_r <= S_RD;
              end
            end else begin
              k_r <= k_r + 2'd1;
            end
          end else begin
            state_r <= S_U_WAIT;
          end
        end
        S_U_WAIT: begin
          if (div_rsp.done) begin
            u_r[k_r] <= div_q[30:0];
            if (k_r == 2'd2) begin
              k_r <= 2'd0;
              if (ov_r) begin
                state_r <= S_OV_ISSUE;
              end else if (sum_r == 64'd0) begin
                idx_r   <= idx_r + CNT_W'(1);
                state_r <= S_RD;
              end else begin
                state_r <= S_T_GO;
              end
            end else begin
              k_r     <= k_r + 2'd1;
              state_r <= S_U_GO;
            end
          end
        end
        S_OV_ISSUE: state_r <= S_OV_TAKE;
        S_OV_TAKE: begin
          out_r[k_r] <= sat32(neg_r[k_r] ? $signed(ovmag_w) : -$signed(ovmag_w));
          if (k_r == 2'd2) begin
            out_ov_r    <= 1'b1;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end else begin
            k_r     <= k_r + 2'd1;
            state_r <= S_OV_ISSUE;
          end
        end
        S_T_GO: state_r <= S_T_WAIT;
        S_T_WAIT: begin
          if (div_rsp.done) begin
            t_r     <= div_q;
            state_r <= S_TLO_ISSUE;
          end
        end
        S_TLO_ISSUE: state_r <= S_TLO_TAKE;
        S_TLO_TAKE: begin
          plo_r   <= prod_r;
          state_r <= S_THI_ISSUE;
        end
        S_THI_ISSUE: state_r <= S_THI_TAKE;
        S_THI_TAKE: begin
          acc_r[k_r] <= neg_r[k_r] ? acc_r[k_r] + $signed(mag_w)
                                   : acc_r[k_r] - $signed(mag_w);
          if (k_r == 2'd2) begin
            k_r     <= 2'd0;
            idx_r   <= idx_r + CNT_W'(1);
            state_r <= S_RD;
          end else begin
            k_r     <= k_r + 2'd1;
            state_r <= S_T_GO;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // A result is only ever presented as the sequencer returns to idle.
  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result presented while the sequencer is still working");

  a_valid_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result presented without a preceding query");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> (idx_r <= n_lim))
    else $error("point walk ran past the configured count");

endmodule
